>>> hw/rtl/fpx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpx_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] DIR_UP     = 8'hAA;
    localparam logic [7:0] DIR_DOWN   = 8'hAF;

    typedef enum logic [2:0] {
        ST_START1,
        ST_START2,
        ST_ID,
        ST_LEN,
        ST_DATA,
        ST_CHK,
        ST_EMIT_RD,
        ST_EMIT_WR
    } fpx_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_id;
        logic ld_len;
        logic wr_data;
        logic rd_clear;
        logic rd_advance;
        logic out_load;
    } fpx_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic is_dir;
        logic len_over;
        logic len_zero;
        logic data_done;
        logic chk_ok;
        logic rd_last;
        logic out_free;
    } fpx_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/fpx_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fpx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fpx_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fpx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_id;
    logic [5:0] payload_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;

    modport source (
        output valid, output message_id, output payload_length, output byte_index,
        output payload_byte, output byte_valid, output last, input ready
    );
    modport sink (
        input valid, input message_id, input payload_length, input byte_index,
        input payload_byte, input byte_valid, input last, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/frame_parser_xor_checksum.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-framed packet receiver. Each input transaction carries one received byte, and the
// parser looks for frames made of the start byte 0xAA, a direction byte (0xAA or 0xAF),
// a message id, a length, that many payload bytes and a checksum equal to the XOR of the
// id, the length and the payload. While it parses, the block takes one byte per clock
// cycle. A length above MAX_PAYLOAD or a wrong checksum drops the frame with no output.
// When the checksum matches, the input side is held off and the frame leaves as a run
// of output transactions, one per payload byte with the last one marked; an empty frame
// gives a single transaction with byte_valid low. Each result of the run goes through the
// registered read of the payload memory and then the load of the output register, and
// the input stays held off until the last result of the run has been loaded, also while
// the output side stalls. The output register keeps the last result on offer while
// parsing of the next frame is already under way.

module frame_parser_xor_checksum
    import fpx_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fpx_in_if.sink    in_ch,
    fpx_out_if.source out_ch
);

    // The controller sequences the parse and the output run; the datapath holds the
    // frame fields, the running checksum, the payload memory and the output register.
    fpx_cmd_t cmd;
    fpx_sts_t sts;

    fpx_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fpx_datapath #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (in_ch.rx_byte),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .message_id    (out_ch.message_id),
        .payload_length(out_ch.payload_length),
        .byte_index    (out_ch.byte_index),
        .payload_byte  (out_ch.payload_byte),
        .byte_valid    (out_ch.byte_valid),
        .last          (out_ch.last)
    );

    // A result is only loaded during the output run, when no byte can be taken.
    a_no_load_while_ready: assert property (
        @(posedge clk) disable iff (!rst_n) !(cmd.out_load && in_ch.ready)
    ) else $error("output loaded while input is open");

    // The output register is never overwritten while it still holds a result.
    a_load_into_free_slot: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.out_load |-> sts.out_free
    ) else $error("output register overwritten");

    // A matching checksum closes the input for the first read of the run.
    a_run_closes_input: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.rd_clear |=> !in_ch.ready
    ) else $error("input open after frame accepted");

    // The result of an empty frame is always the whole run.
    a_empty_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.byte_valid) |-> out_ch.last
    ) else $error("empty-frame result not marked last");

endmodule

`default_nettype wire

>>> hw/rtl/fpx_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fpx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fpx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fpx_ctrl
    import fpx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire fpx_sts_t sts,
    output fpx_cmd_t      cmd
);

    fpx_state_t state_reg;
    fpx_state_t state_next;
    logic       acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready   = (state_reg != ST_EMIT_RD) && (state_reg != ST_EMIT_WR);
        acc        = in_valid && in_ready;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_START1:
            begin
                if (acc)
                begin
                    state_next = sts.is_start ? ST_START2 : ST_START1;
                end
            end
            ST_START2:
            begin
                if (acc)
                begin
                    state_next = sts.is_dir ? ST_ID : ST_START1;
                end
            end
            ST_ID:
            begin
                if (acc)
                begin
                    cmd.ld_id  = 1'b1;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (acc)
                begin
                    if (sts.len_over)
                    begin
                        state_next = ST_START1;
                    end
                    else
                    begin
                        cmd.ld_len = 1'b1;
                        state_next = sts.len_zero ? ST_CHK : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (acc)
                begin
                    cmd.wr_data = 1'b1;
                    state_next  = sts.data_done ? ST_CHK : ST_DATA;
                end
            end
            ST_CHK:
            begin
                if (acc)
                begin
                    if (sts.chk_ok)
                    begin
                        cmd.rd_clear = 1'b1;
                        state_next   = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_START1;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.rd_last)
                    begin
                        state_next = ST_START1;
                    end
                    else
                    begin
                        cmd.rd_advance = 1'b1;
                        state_next     = ST_EMIT_RD;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/fpx_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fpx_datapath
    import fpx_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] rx_byte,
    input  wire fpx_cmd_t   cmd,
    output fpx_sts_t        sts,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [7:0]      message_id,
    output logic [5:0]      payload_length,
    output logic [4:0]      byte_index,
    output logic [7:0]      payload_byte,
    output logic            byte_valid,
    output logic            last
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]       id_reg;
    logic [7:0]       xor_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] wpos_reg;
    logic [LEN_W-1:0] ridx_reg;

    logic       out_valid_reg;
    logic [7:0] out_id_reg;
    logic [5:0] out_len_reg;
    logic [4:0] out_idx_reg;
    logic [7:0] out_byte_reg;
    logic       out_bvalid_reg;
    logic       out_last_reg;

    logic [7:0]       ram_rd_data;
    logic [LEN_W:0]   wpos_inc;
    logic [LEN_W:0]   ridx_inc;
    logic [LEN_W+5:0] len_ext;
    logic [LEN_W+4:0] idx_ext;
    logic             len_nonzero;

    assign wpos_inc    = (LEN_W + 1)'(wpos_reg) + (LEN_W + 1)'(1);
    assign ridx_inc    = (LEN_W + 1)'(ridx_reg) + (LEN_W + 1)'(1);
    assign len_ext     = {6'd0, len_reg};
    assign idx_ext     = {5'd0, ridx_reg};
    assign len_nonzero = (len_reg != '0);

    always_comb
    begin
        sts.is_start  = (rx_byte == START_BYTE);
        sts.is_dir    = (rx_byte == DIR_UP) || (rx_byte == DIR_DOWN);
        sts.len_over  = (rx_byte > 8'(MAX_PAYLOAD));
        sts.len_zero  = (rx_byte == 8'd0);
        sts.data_done = (wpos_inc == (LEN_W + 1)'(len_reg));
        sts.chk_ok    = (rx_byte == xor_reg);
        sts.rd_last   = !len_nonzero || (ridx_inc == (LEN_W + 1)'(len_reg));
        sts.out_free  = !out_valid_reg || out_ready;
    end

    fpx_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .clk    (clk),
        .wr_en  (cmd.wr_data),
        .wr_addr(wpos_reg[ADDR_W-1:0]),
        .wr_data(rx_byte),
        .rd_addr(ridx_reg[ADDR_W-1:0]),
        .rd_data(ram_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.ld_id)
        begin
            id_reg  <= rx_byte;
            xor_reg <= rx_byte;
        end
        else if (cmd.ld_len || cmd.wr_data)
        begin
            xor_reg <= xor_reg ^ rx_byte;
        end
        if (cmd.ld_len)
        begin
            len_reg <= rx_byte[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            ridx_reg <= '0;
        end
        else
        begin
            if (cmd.ld_len)
            begin
                wpos_reg <= '0;
            end
            else if (cmd.wr_data)
            begin
                wpos_reg <= wpos_inc[LEN_W-1:0];
            end
            if (cmd.rd_clear)
            begin
                ridx_reg <= '0;
            end
            else if (cmd.rd_advance)
            begin
                ridx_reg <= ridx_inc[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_id_reg     <= id_reg;
            out_len_reg    <= len_ext[5:0];
            out_idx_reg    <= idx_ext[4:0];
            out_byte_reg   <= len_nonzero ? ram_rd_data : 8'd0;
            out_bvalid_reg <= len_nonzero;
            out_last_reg   <= sts.rd_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign message_id     = out_id_reg;
    assign payload_length = out_len_reg;
    assign byte_index     = out_idx_reg;
    assign payload_byte   = out_byte_reg;
    assign byte_valid     = out_bvalid_reg;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

>>> tb/fpx_frame_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the frame parser and predicts, byte by byte, which
// payload runs it has to deliver. Every output transaction is compared with the
// oldest predicted one.
module fpx_frame_checker
    import fpx_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fpx_in_if         in_ch,
    fpx_out_if        out_ch,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [7:0] message_id;
        logic [5:0] payload_length;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } payload_beat_t;

    fpx_state_t    parse_state;
    logic [7:0]    frame_id;
    logic [5:0]    frame_len;
    logic [5:0]    fill_pos;
    logic [7:0]    xor_acc;
    logic [7:0]    payload_mem [MAX_PAYLOAD];
    payload_beat_t beats_due [$];

    // Queues the whole run of a frame whose checksum matched.
    task automatic queue_frame_run();
        payload_beat_t beat;
        beat.message_id     = frame_id;
        beat.payload_length = frame_len;
        if (frame_len == 0) begin
            beat.byte_index   = '0;
            beat.payload_byte = '0;
            beat.byte_valid   = 1'b0;
            beat.last         = 1'b1;
            beats_due.push_back(beat);
        end else begin
            for (int i = 0; i < frame_len; i++) begin
                beat.byte_index   = 5'(i);
                beat.payload_byte = payload_mem[i];
                beat.byte_valid   = 1'b1;
                beat.last         = (i + 1 == frame_len);
                beats_due.push_back(beat);
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (parse_state)
            ST_START2: begin
                if (b == DIR_UP || b == DIR_DOWN)
                    parse_state = ST_ID;
                else if (b != START_BYTE)
                    parse_state = ST_START1;
            end
            ST_ID: begin
                frame_id    = b;
                xor_acc     = b;
                parse_state = ST_LEN;
            end
            ST_LEN: begin
                xor_acc = xor_acc ^ b;
                if (b > MAX_PAYLOAD) begin
                    parse_state = ST_START1;
                end else begin
                    frame_len   = 6'(b);
                    fill_pos    = '0;
                    parse_state = (b == 0) ? ST_CHK : ST_DATA;
                end
            end
            ST_DATA: begin
                if (fill_pos < MAX_PAYLOAD)
                    payload_mem[fill_pos] = b;
                xor_acc  = xor_acc ^ b;
                fill_pos = fill_pos + 1'b1;
                if (fill_pos >= frame_len)
                    parse_state = ST_CHK;
            end
            ST_CHK: begin
                if (b == xor_acc)
                    queue_frame_run();
                parse_state = ST_START1;
            end
            default: begin
                parse_state = (b == START_BYTE) ? ST_START2 : ST_START1;
            end
        endcase
    endtask

    task automatic check_beat(input payload_beat_t got);
        payload_beat_t want;
        if (beats_due.size() == 0) begin
            $error("unexpected output transaction: message_id %0h byte_index %0d",
                   got.message_id, got.byte_index);
            fail_count <= fail_count + 1;
            return;
        end
        want = beats_due.pop_front();
        if (got.message_id !== want.message_id)
            $error("message_id: expected %0h, got %0h", want.message_id, got.message_id);
        if (got.payload_length !== want.payload_length)
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, got.payload_length);
        if (got.byte_index !== want.byte_index)
            $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
        if (got.payload_byte !== want.payload_byte)
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        if (got.byte_valid !== want.byte_valid)
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
        if (got.last !== want.last)
            $error("last: expected %0b, got %0b", want.last, got.last);
        if (got !== want)
            fail_count <= fail_count + 1;
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            parse_state = ST_START1;
            frame_id    = '0;
            frame_len   = '0;
            fill_pos    = '0;
            xor_acc     = '0;
            beats_due.delete();
            pending <= 0;
        end else begin
            // A result leaving now always belongs to a byte taken earlier, so
            // the output side is checked before this edge's byte is parsed.
            if (out_ch.valid && out_ch.ready)
                check_beat({out_ch.message_id, out_ch.payload_length, out_ch.byte_index,
                            out_ch.payload_byte, out_ch.byte_valid, out_ch.last});
            if (in_ch.valid && in_ch.ready)
                parse_byte(in_ch.rx_byte);
            pending <= beats_due.size();
        end
    end

endmodule

>>> tb/frame_parser_xor_checksum_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the frame parser. The checker beside the block does all
// prediction and comparison; this module only produces byte traffic, backpressure on
// the output side, and decides pass or fail once everything has drained.
module frame_parser_xor_checksum_tb
    import fpx_pkg::*;
();

    localparam int BYTE_TARGET   = 410;
    localparam int IDLE_PERCENT  = 13;
    // Long output stall; the parser fills up and must hold its input off meanwhile.
    localparam int HOLD_CYCLES   = 300;
    // Longest stretch with no transaction on either side before the run is abandoned.
    // The output hold above is the longest legitimate quiet period.
    localparam int QUIET_LIMIT   = 4000;
    // Watch time after draining, sized from the payload length of a full frame.
    localparam int DRAIN_CYCLES  = 2 * MAX_PAYLOAD_DEF + 16;

    logic clk;
    logic rst_n;

    fpx_in_if  in_ch ();
    fpx_out_if out_ch ();

    int fail_count;
    int pending;
    int bytes_sent;
    // While calm is set neither side inserts idle cycles.
    bit calm;
    bit hold_request;

    frame_parser_xor_checksum u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    fpx_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offers one byte, with an occasional idle gap first, and returns once the
    // transaction has been taken. Valid is left high so back-to-back bytes flow.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends a complete frame with random payload. An oversized length ends the frame
    // right after the length byte, since the parser goes back to hunting there.
    // A bad frame gets its checksum flipped by a nonzero pattern.
    task automatic send_frame(input logic [7:0] id, input logic [7:0] dir,
                              input logic [7:0] len, input bit good);
        logic [7:0] sum;
        logic [7:0] data;
        sum = id ^ len;
        send_byte(START_BYTE);
        send_byte(dir);
        send_byte(id);
        send_byte(len);
        if (len > MAX_PAYLOAD_DEF)
            return;
        for (int i = 0; i < len; i++)
        begin
            data = 8'($urandom);
            sum  = sum ^ data;
            send_byte(data);
        end
        send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
    endtask

    // Output side: random stalls, a stall-free stretch when calm is set, and one long
    // hold-off when the stimulus asks for it. The hold is counted here, not by the
    // sender, so the sender keeps offering bytes throughout.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (!rst_n)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (calm)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog: a hung block shows up as a long period without any transaction.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        // Directed opening: every framing path once.
        //   - empty frame with the down direction code, id and checksum zero;
        //   - a repeated start byte taken as the up direction code, id 0xFF with a
        //     single 0xFF payload byte;
        //   - a start byte followed by a byte that is no direction code;
        //   - a length one above the maximum, which drops the frame;
        //   - a two-byte frame with a wrong checksum.
        logic [7:0] directed [];
        int         frame_no;
        int         pick;
        int         noise_len;
        logic [7:0] len;
        logic [7:0] dir;
        logic [7:0] odd;

        directed = '{
            8'hAA, 8'hAF, 8'h00, 8'h00, 8'h00,
            8'hAA, 8'hAA, 8'hFF, 8'h01, 8'hFF, 8'h01,
            8'hAA, 8'h00,
            8'hAA, 8'hAF, 8'h07, 8'h21,
            8'hAA, 8'hAF, 8'h33, 8'h02, 8'h00, 8'h11, 8'h21
        };
        rst_n         = 1'b0;
        calm          = 1'b0;
        hold_request  = 1'b0;
        bytes_sent    = 0;
        frame_no      = 0;
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i]);

        // Random part: mostly well-formed frames with random content, with noise,
        // broken headers, oversized lengths and bad checksums mixed in.
        while (bytes_sent < BYTE_TARGET)
        begin
            calm = (frame_no >= 10 && frame_no < 18);
            dir  = $urandom_range(0, 1) ? DIR_UP : DIR_DOWN;
            pick = $urandom_range(0, 99);
            if (frame_no == 3 || frame_no == 25)
            begin
                // Full-size frames; the second one runs into the long output hold.
                if (frame_no == 25)
                    hold_request = 1'b1;
                send_frame(8'($urandom), dir, 8'(MAX_PAYLOAD_DEF), 1'b1);
            end
            else if (pick < 6)
            begin
                noise_len = $urandom_range(1, 4);
                repeat (noise_len)
                    send_byte($urandom_range(0, 3) == 0 ? START_BYTE : 8'($urandom));
            end
            else if (pick < 10)
            begin
                odd = 8'($urandom);
                if (odd == DIR_UP || odd == DIR_DOWN)
                    odd = 8'h00;
                send_byte(START_BYTE);
                send_byte(odd);
            end
            else if (pick < 16)
            begin
                send_frame(8'($urandom), dir, 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)),
                           1'b1);
            end
            else
            begin
                if ($urandom_range(0, 99) < 8)
                    len = 8'($urandom_range(MAX_PAYLOAD_DEF - 7, MAX_PAYLOAD_DEF));
                else
                    len = 8'($urandom_range(0, 8));
                send_frame(8'($urandom), dir, len, $urandom_range(0, 99) < 85);
            end
            frame_no++;
        end
        in_ch.valid <= 1'b0;

        // Let every predicted transaction arrive, then watch a while longer for
        // anything extra the block might still send.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
